FILE: rtl/core/erss_pkg.sv
`timescale 1ns / 1ps

package erss_pkg;

    // Default pattern capacity in steps
    localparam int MAX_LEN_DEF = 16;

    // Configuration port
    localparam int CFG_W = 5;
    localparam int IDX_W = 3;

    // Register field widths
    localparam int STEPS_W    = 5;
    localparam int ROT_W      = 4;
    localparam int CHAIN_W    = 2;
    localparam int STEP_NOW_W = 4;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_STEP_TOTAL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_HIT_TOTAL    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROTATION     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PAD_STEPS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ACCENT_TOTAL = 3'd4;
    localparam logic [IDX_W-1:0] REG_ACCENT_SHIFT = 3'd5;
    localparam logic [IDX_W-1:0] REG_CHAIN_MODE   = 3'd6;
    localparam logic [IDX_W-1:0] REG_START_WIRED  = 3'd7;

    // Chain mode codes (three acts as leader)
    localparam logic [CHAIN_W-1:0] CHAIN_FREE     = 2'd0;
    localparam logic [CHAIN_W-1:0] CHAIN_LEADER   = 2'd1;
    localparam logic [CHAIN_W-1:0] CHAIN_FOLLOWER = 2'd2;

    // Reset values of the registers
    localparam logic [STEPS_W-1:0] STEP_TOTAL_RST = 5'd16;
    localparam logic [STEPS_W-1:0] HIT_TOTAL_RST  = 5'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_ROT,
        ST_HSTART,
        ST_HITEM,
        ST_HREST,
        ST_ASTART,
        ST_AITEM,
        ST_AREST,
        ST_IDLE
    } erss_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic rot_sub;
        logic pass_start;
        logic acc_pass;
        logic place;
        logic rest;
        logic next_item;
        logic tick;
    } erss_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic steps_zero;
        logic rot_big;
        logic more_items;
        logic rest_more;
    } erss_status_t;

endpackage

FILE: rtl/core/erss_if.sv
`timescale 1ns / 1ps

// Tick channel: edge flags of one audio-rate tick
interface erss_tick_if;
    logic valid;
    logic ready;
    logic reset_edge;
    logic mute_edge;
    logic start_edge;
    logic clock_edge;

    modport source (
        output valid, reset_edge, mute_edge, start_edge, clock_edge,
        input  ready
    );
    modport sink (
        input  valid, reset_edge, mute_edge, start_edge, clock_edge,
        output ready
    );
endinterface

// Beat channel: result of one tick
interface erss_beat_if;
    logic                                valid;
    logic                                ready;
    logic                                beat_on;
    logic                                accent_on;
    logic                                cycle_end;
    logic                                is_running;
    logic [erss_pkg::STEP_NOW_W-1:0]     step_now;

    modport source (
        output valid, beat_on, accent_on, cycle_end, is_running, step_now,
        input  ready
    );
    modport sink (
        input  valid, beat_on, accent_on, cycle_end, is_running, step_now,
        output ready
    );
endinterface

FILE: rtl/core/erss_ctrl.sv
`timescale 1ns / 1ps

module erss_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  erss_pkg::erss_status_t status,
    output erss_pkg::erss_cmd_t    cmd,
    input  logic                   cfg_we,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready
);

    erss_pkg::erss_state_t state_reg;
    erss_pkg::erss_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= erss_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state: any config write restarts the pattern build
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            erss_pkg::ST_CLEAR:
                state_next = status.steps_zero ? erss_pkg::ST_IDLE : erss_pkg::ST_ROT;
            erss_pkg::ST_ROT:
                if (!status.rot_big)
                    state_next = erss_pkg::ST_HSTART;
            erss_pkg::ST_HSTART:
                state_next = erss_pkg::ST_HITEM;
            erss_pkg::ST_HITEM:
                state_next = status.more_items ? erss_pkg::ST_HREST : erss_pkg::ST_ASTART;
            erss_pkg::ST_HREST:
                if (!status.rest_more)
                    state_next = erss_pkg::ST_HITEM;
            erss_pkg::ST_ASTART:
                state_next = erss_pkg::ST_AITEM;
            erss_pkg::ST_AITEM:
                state_next = status.more_items ? erss_pkg::ST_AREST : erss_pkg::ST_IDLE;
            erss_pkg::ST_AREST:
                if (!status.rest_more)
                    state_next = erss_pkg::ST_AITEM;
            erss_pkg::ST_IDLE:
                state_next = erss_pkg::ST_IDLE;
            default:
                state_next = erss_pkg::ST_CLEAR;
        endcase
        if (cfg_we)
            state_next = erss_pkg::ST_CLEAR;
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            erss_pkg::ST_CLEAR:
                cmd.clear = 1'b1;
            erss_pkg::ST_ROT:
                cmd.rot_sub = status.rot_big;
            erss_pkg::ST_HSTART:
            begin
                cmd.pass_start = 1'b1;
                cmd.acc_pass   = 1'b0;
            end
            erss_pkg::ST_HITEM,
            erss_pkg::ST_AITEM:
                cmd.place = status.more_items;
            erss_pkg::ST_HREST,
            erss_pkg::ST_AREST:
            begin
                cmd.rest      = status.rest_more;
                cmd.next_item = !status.rest_more;
            end
            erss_pkg::ST_ASTART:
            begin
                cmd.pass_start = 1'b1;
                cmd.acc_pass   = 1'b1;
            end
            erss_pkg::ST_IDLE:
                in_ready = !cfg_we && (!out_valid_reg || out_ready);
            default:
                cmd = '0;
        endcase
        cmd.tick = in_valid && in_ready;
    end

    // Output register valid: load on tick, drop when taken
    always_comb
    begin
        if (cmd.tick)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/erss_dp.sv
`timescale 1ns / 1ps

module erss_dp #(
    parameter int MAX_LEN = erss_pkg::MAX_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  erss_pkg::erss_cmd_t               cmd,
    output erss_pkg::erss_status_t            status,
    input  logic                              cfg_we,
    input  logic [erss_pkg::IDX_W-1:0]        cfg_idx,
    input  logic [erss_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              reset_edge,
    input  logic                              mute_edge,
    input  logic                              start_edge,
    input  logic                              clock_edge,
    output logic                              beat_on,
    output logic                              accent_on,
    output logic                              cycle_end,
    output logic                              is_running,
    output logic [erss_pkg::STEP_NOW_W-1:0]   step_now
);

    localparam int POS_W = $clog2(MAX_LEN);
    localparam int LW    = ($clog2(MAX_LEN + 1) > erss_pkg::STEPS_W) ?
                           $clog2(MAX_LEN + 1) : erss_pkg::STEPS_W;
    localparam int CW    = LW + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

    // Configuration registers
    logic [erss_pkg::STEPS_W-1:0] steps_cfg_reg;
    logic [erss_pkg::STEPS_W-1:0] hits_cfg_reg;
    logic [erss_pkg::ROT_W-1:0]   rot_cfg_reg;
    logic [erss_pkg::STEPS_W-1:0] pad_cfg_reg;
    logic [erss_pkg::STEPS_W-1:0] acc_cfg_reg;
    logic [erss_pkg::ROT_W-1:0]   ash_cfg_reg;
    logic [erss_pkg::CHAIN_W-1:0] chain_reg;
    logic                         wired_reg;

    // Clamped pattern figures
    logic [CW-1:0] steps_raw, hits_raw, pad_raw, acc_raw, ash_raw;
    logic [CW-1:0] steps, hits, room, pad, acc, ash, r_hit, r_acc;
    logic          chained;
    logic          restart_run;
    logic          restart_on_write;

    // Pattern builder
    logic [CW-1:0]     rotm_reg;
    logic [CW-1:0]     t_reg;
    logic [CW-1:0]     q_reg;
    logic [CW-1:0]     j_reg;
    logic              pass_reg;
    logic [MAX_LEN-1:0] hit_map_reg;
    logic [MAX_LEN-1:0] acc_map_reg;
    logic [POS_W-1:0]  loc_reg [MAX_LEN];
    logic [CW-1:0]     n_sel, r_sel, s_sel, m_sel, sum, p_full;
    logic [POS_W-1:0]  p_idx;
    logic [POS_W-1:0]  j_idx;
    logic [POS_W-1:0]  loc_rd;

    // Track state and tick logic
    logic [POS_W-1:0]  pos_reg;
    logic              run_reg;
    logic              mute_reg;
    logic [POS_W-1:0]  pos1, pos_next;
    logic              run1, run2, run_next;
    logic              mute_next;
    logic              advance, wrap;
    logic [CW-1:0]     inc;
    logic [CW-1:0]     pos_ext;

    // Output payload registers
    logic                            beat_reg;
    logic                            accent_reg;
    logic                            cycle_end_reg;
    logic                            running_reg;
    logic [erss_pkg::STEP_NOW_W-1:0] step_now_reg;

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_cfg_reg <= erss_pkg::STEP_TOTAL_RST;
            hits_cfg_reg  <= erss_pkg::HIT_TOTAL_RST;
            rot_cfg_reg   <= '0;
            pad_cfg_reg   <= '0;
            acc_cfg_reg   <= '0;
            ash_cfg_reg   <= '0;
            chain_reg     <= erss_pkg::CHAIN_FREE;
            wired_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                erss_pkg::REG_STEP_TOTAL:   steps_cfg_reg <= cfg_data;
                erss_pkg::REG_HIT_TOTAL:    hits_cfg_reg  <= cfg_data;
                erss_pkg::REG_ROTATION:     rot_cfg_reg   <= cfg_data[erss_pkg::ROT_W-1:0];
                erss_pkg::REG_PAD_STEPS:    pad_cfg_reg   <= cfg_data;
                erss_pkg::REG_ACCENT_TOTAL: acc_cfg_reg   <= cfg_data;
                erss_pkg::REG_ACCENT_SHIFT: ash_cfg_reg   <= cfg_data[erss_pkg::ROT_W-1:0];
                erss_pkg::REG_CHAIN_MODE:   chain_reg     <= cfg_data[erss_pkg::CHAIN_W-1:0];
                erss_pkg::REG_START_WIRED:  wired_reg     <= cfg_data[0];
                default:                    wired_reg     <= wired_reg;
            endcase
        end
    end

    // Clamps: steps to capacity, hits to steps, pad to free room, accents to hits, accent shift below hits
    always_comb
    begin
        steps_raw = CW'(steps_cfg_reg);
        hits_raw  = CW'(hits_cfg_reg);
        pad_raw   = CW'(pad_cfg_reg);
        acc_raw   = CW'(acc_cfg_reg);
        ash_raw   = CW'(ash_cfg_reg);
        steps     = (steps_raw > MAX_C) ? MAX_C : steps_raw;
        hits      = (hits_raw > steps) ? steps : hits_raw;
        room      = steps - hits;
        pad       = (pad_raw > room) ? room : pad_raw;
        acc       = (acc_raw > hits) ? hits : acc_raw;
        if (hits == '0)
            ash = '0;
        else
            ash = (ash_raw > hits - CW'(1)) ? hits - CW'(1) : ash_raw;
        r_hit     = room - pad;
        r_acc     = hits - acc;
    end

    assign chained          = (chain_reg != erss_pkg::CHAIN_FREE) && wired_reg;
    assign restart_run      = !((chain_reg == erss_pkg::CHAIN_FOLLOWER) && wired_reg);
    assign restart_on_write = !((cfg_data[erss_pkg::CHAIN_W-1:0] == erss_pkg::CHAIN_FOLLOWER)
                                && wired_reg);

    // Spread engine operands: hit pass or accent pass
    always_comb
    begin
        n_sel  = pass_reg ? acc   : hits;
        r_sel  = pass_reg ? r_acc : r_hit;
        s_sel  = pass_reg ? ash   : rotm_reg;
        m_sel  = pass_reg ? hits  : steps;
        sum    = t_reg + s_sel;
        p_full = (sum >= m_sel) ? sum - m_sel : sum;
        p_idx  = p_full[POS_W-1:0];
        j_idx  = j_reg[POS_W-1:0];
        loc_rd = loc_reg[p_idx];
    end

    assign status.steps_zero = (steps == '0);
    assign status.rot_big    = (rotm_reg >= steps);
    assign status.more_items = (j_reg < n_sel);
    assign status.rest_more  = (q_reg < r_sel);

    // Pattern builder: one hit or one rest per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            hit_map_reg <= '0;
            acc_map_reg <= '0;
            rotm_reg    <= CW'(rot_cfg_reg);
        end
        else if (cmd.rot_sub)
        begin
            rotm_reg <= rotm_reg - steps;
        end
        else if (cmd.pass_start)
        begin
            pass_reg <= cmd.acc_pass;
            t_reg    <= cmd.acc_pass ? '0 : pad;
            j_reg    <= '0;
        end
        else if (cmd.place)
        begin
            t_reg <= t_reg + CW'(1);
            q_reg <= j_reg;
            if (pass_reg)
                acc_map_reg[loc_rd] <= 1'b1;
            else
            begin
                hit_map_reg[p_idx] <= 1'b1;
                loc_reg[j_idx]     <= p_idx;
            end
        end
        else if (cmd.rest)
        begin
            t_reg <= t_reg + CW'(1);
            q_reg <= q_reg + n_sel;
        end
        else if (cmd.next_item)
        begin
            j_reg <= j_reg + CW'(1);
        end
    end

    // Tick: reset edge, mute edge, start edge, clock edge in that order
    always_comb
    begin
        run1      = reset_edge ? restart_run : run_reg;
        pos1      = reset_edge ? '0 : pos_reg;
        mute_next = mute_reg ^ mute_edge;
        run2      = (start_edge && chained) ? 1'b1 : run1;
        advance   = clock_edge && run2;
        inc       = CW'(pos1) + CW'(1);
        wrap      = advance && (inc >= steps);
        if (wrap)
            pos_next = '0;
        else if (advance)
            pos_next = inc[POS_W-1:0];
        else
            pos_next = pos1;
        run_next  = (wrap && chained) ? 1'b0 : run2;
        pos_ext   = CW'(pos_next);
    end

    // Track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            run_reg  <= 1'b1;
            mute_reg <= 1'b0;
        end
        else if (cmd.tick)
        begin
            pos_reg  <= pos_next;
            run_reg  <= run_next;
            mute_reg <= mute_next;
        end
        else if (cfg_we && (cfg_idx == erss_pkg::REG_CHAIN_MODE))
        begin
            run_reg <= restart_on_write;
        end
    end

    // Result register, loaded only when the output side can take it
    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            beat_reg      <= hit_map_reg[pos_next] && run_next && !mute_next;
            accent_reg    <= acc_map_reg[pos_next] && run_next && !mute_next;
            cycle_end_reg <= wrap;
            running_reg   <= run_next;
            step_now_reg  <= pos_ext[erss_pkg::STEP_NOW_W-1:0];
        end
    end

    assign beat_on    = beat_reg;
    assign accent_on  = accent_reg;
    assign cycle_end  = cycle_end_reg;
    assign is_running = running_reg;
    assign step_now   = step_now_reg;

endmodule

FILE: rtl/core/euclidean_rhythm_step_sequencer.sv
`timescale 1ns / 1ps

// One track of a Euclidean rhythm sequencer. Each tick transaction carries
// reset, mute, start and clock edge flags and yields one beat transaction
// with beat, accent, end-of-cycle, running flag and step index. Once the
// pattern is built, a tick is accepted while no configuration write is
// present, whenever the output register is empty or being drained in the
// same cycle. After reset and after every configuration write the hit and
// accent maps are rebuilt by a shared spreading unit that places one hit or
// one rest per cycle; tick ready stays low during that build. Configuration
// writes are taken in any cycle and a new write restarts the build.
module euclidean_rhythm_step_sequencer #(
    parameter int MAX_LEN = erss_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [erss_pkg::IDX_W-1:0]    cfg_idx,
    input  logic [erss_pkg::CFG_W-1:0]    cfg_data,
    erss_tick_if.sink                     tick,
    erss_beat_if.source                   beat
);

    erss_pkg::erss_cmd_t    cmd;
    erss_pkg::erss_status_t status;

    // Build sequencer and handshake control
    erss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (beat.valid),
        .out_ready (beat.ready)
    );

    // Config, pattern maps and track state
    erss_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .reset_edge (tick.reset_edge),
        .mute_edge  (tick.mute_edge),
        .start_edge (tick.start_edge),
        .clock_edge (tick.clock_edge),
        .beat_on    (beat.beat_on),
        .accent_on  (beat.accent_on),
        .cycle_end  (beat.cycle_end),
        .is_running (beat.is_running),
        .step_now   (beat.step_now)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import erss_pkg::*;

    // Edge flags of one tick transaction
    typedef struct packed {
        logic rst_e;
        logic mute_e;
        logic start_e;
        logic clk_e;
    } tick_t;

    // Fields of one beat transaction
    typedef struct packed {
        logic                  beat_on;
        logic                  accent_on;
        logic                  cycle_end;
        logic                  is_running;
        logic [STEP_NOW_W-1:0] step_now;
    } beat_t;

    localparam int CALM_LO   = 100;  // no idling on either side in this window
    localparam int CALM_HI   = 260;
    localparam int STALL_AT  = 300;  // receiver holds off after this many beats
    localparam int STALL_LEN = 80;
    localparam int DRAIN_AT  = 450;  // sender waits for all beats after this many ticks

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    erss_tick_if tick_ch ();
    erss_beat_if beat_ch ();

    euclidean_rhythm_step_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .tick     (tick_ch),
        .beat     (beat_ch)
    );

    always #5 clk = ~clk;

    // Track model: registers, position, flags and the two patterns
    logic [4:0]  trk_reg [0:7];
    logic [4:0]  trk_pos;
    logic        trk_run;
    logic        trk_mute;
    logic [15:0] hit_pattern;
    logic [15:0] accent_pattern;

    tick_t tick_backlog [$];
    beat_t due_beats [$];
    int    n_ticks = 0;
    int    n_beats = 0;
    int    errors = 0;
    logic  drain_hold = 1'b0;
    int    stall_left = 0;

    function automatic logic [4:0] reg_mask(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_ROTATION, REG_ACCENT_SHIFT: return 5'd15;
            REG_CHAIN_MODE:                 return 5'd3;
            REG_START_WIRED:                return 5'd1;
            default:                        return 5'd31;
        endcase
    endfunction

    // Upper end of the documented range of each register
    function automatic int reg_top(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_ROTATION, REG_ACCENT_SHIFT: return 15;
            REG_CHAIN_MODE:                 return 2;
            REG_START_WIRED:                return 1;
            default:                        return MAX_LEN_DEF;
        endcase
    endfunction

    // Rests that follow item j when r rests are spread over groups of h
    function automatic int unsigned rest_share(input int unsigned r, input int unsigned h,
                                               input int unsigned j);
        int unsigned n;
        n = 0;
        for (int unsigned k = 0; k < MAX_LEN_DEF; k++)
            if (r > k * h + j)
                n++;
        return n;
    endfunction

    // Rebuild hit and accent patterns from the register copy
    function automatic void rebuild_patterns();
        int unsigned spot [0:15];
        int unsigned steps, hits, rot, pad, acc, ash, rests, t, p;
        steps = (trk_reg[REG_STEP_TOTAL] > MAX_LEN_DEF) ? MAX_LEN_DEF
                                                         : trk_reg[REG_STEP_TOTAL];
        hits  = (trk_reg[REG_HIT_TOTAL] > steps) ? steps : trk_reg[REG_HIT_TOTAL];
        rot   = trk_reg[REG_ROTATION];
        pad   = (trk_reg[REG_PAD_STEPS] > steps - hits) ? steps - hits
                                                         : trk_reg[REG_PAD_STEPS];
        acc   = (trk_reg[REG_ACCENT_TOTAL] > hits) ? hits : trk_reg[REG_ACCENT_TOTAL];
        ash   = 0;
        if (hits > 0)
            ash = (trk_reg[REG_ACCENT_SHIFT] > hits - 1) ? hits - 1
                                                          : trk_reg[REG_ACCENT_SHIFT];
        hit_pattern = '0;
        accent_pattern = '0;
        for (int j = 0; j < 16; j++)
            spot[j] = 0;
        if (steps == 0)
            return;

        // hits with rests spread after them, then pad and rotation
        rests = steps - hits - pad;
        t = pad;
        for (int unsigned j = 0; j < hits; j++)
        begin
            p = (t + rot) % steps;
            hit_pattern[p] = 1'b1;
            spot[j] = p;
            t += 1 + rest_share(rests, hits, j);
        end

        // same spreading over the hits picks the accented ones
        if (acc == 0)
            return;
        rests = hits - acc;
        t = 0;
        for (int unsigned j = 0; j < acc; j++)
        begin
            accent_pattern[spot[(t + ash) % hits]] = 1'b1;
            t += 1 + rest_share(rests, acc, j);
        end
    endfunction

    function automatic void restart_run();
        trk_run = !(trk_reg[REG_CHAIN_MODE] == CHAIN_FOLLOWER && trk_reg[REG_START_WIRED] == 1);
    endfunction

    function automatic void reset_track();
        for (int i = 0; i < 8; i++)
            trk_reg[i] = '0;
        trk_reg[REG_STEP_TOTAL] = STEP_TOTAL_RST;
        trk_reg[REG_HIT_TOTAL] = HIT_TOTAL_RST;
        trk_pos = '0;
        trk_mute = 1'b0;
        restart_run();
        rebuild_patterns();
    endfunction

    // Advance the track by one tick and form the beat it yields
    function automatic beat_t next_beat(input tick_t t);
        beat_t b;
        int unsigned steps;
        logic chained;
        steps = (trk_reg[REG_STEP_TOTAL] > MAX_LEN_DEF) ? MAX_LEN_DEF
                                                         : trk_reg[REG_STEP_TOTAL];
        chained = (trk_reg[REG_CHAIN_MODE] != CHAIN_FREE) && (trk_reg[REG_START_WIRED] == 1);
        b = '0;
        if (t.rst_e)
        begin
            trk_pos = '0;
            restart_run();
        end
        if (t.mute_e)
            trk_mute = ~trk_mute;
        if (t.start_e && chained && !trk_run)
            trk_run = 1'b1;
        if (t.clk_e && trk_run)
        begin
            trk_pos = trk_pos + 5'd1;
            if (trk_pos >= steps)
            begin
                trk_pos = '0;
                b.cycle_end = 1'b1;
                if (chained)
                    trk_run = 1'b0;
            end
        end
        b.beat_on = hit_pattern[trk_pos[3:0]] && trk_pos < 16 && trk_run && !trk_mute;
        b.accent_on = accent_pattern[trk_pos[3:0]] && trk_pos < 16 && trk_run && !trk_mute;
        b.is_running = trk_run;
        b.step_now = trk_pos[3:0];
        return b;
    endfunction

    // Mostly clock edges, with occasional reset, mute and start; some pure noise
    function automatic tick_t rand_tick();
        tick_t t;
        if ($urandom_range(9) == 0)
            t = tick_t'($urandom_range(15));
        else
        begin
            t.rst_e = ($urandom_range(99) < 4);
            t.mute_e = ($urandom_range(99) < 8);
            t.start_e = ($urandom_range(99) < 20);
            t.clk_e = ($urandom_range(99) < 80);
        end
        return t;
    endfunction

    function automatic logic [CFG_W-1:0] rand_reg(input logic [IDX_W-1:0] idx);
        if ($urandom_range(3) == 0)
            return CFG_W'($urandom_range(31));
        return CFG_W'($urandom_range(reg_top(idx)));
    endfunction

    // One register write per clock; the model takes it at the edge that drives it onto the port
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        trk_reg[idx] = data & reg_mask(idx);
        if (idx == REG_CHAIN_MODE)
            restart_run();
        rebuild_patterns();
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until no tick is queued or offered and every beat has arrived
    task automatic wait_quiet();
        @(negedge clk);
        while (tick_backlog.size() != 0 || tick_ch.valid || due_beats.size() != 0)
            @(negedge clk);
    endtask

    // Tick driver
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        tick_t nxt;
        logic gap;
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.reset_edge <= 1'b0;
            tick_ch.mute_edge <= 1'b0;
            tick_ch.start_edge <= 1'b0;
            tick_ch.clock_edge <= 1'b0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                due_beats.push_back(next_beat({tick_ch.reset_edge, tick_ch.mute_edge,
                                               tick_ch.start_edge, tick_ch.clock_edge}));
                n_ticks++;
                if (n_ticks == DRAIN_AT)
                    drain_hold = 1'b1;
            end
            if (drain_hold && due_beats.size() == 0)
                drain_hold = 1'b0;
            if (!tick_ch.valid || tick_ch.ready)
            begin
                gap = (n_ticks < CALM_LO || n_ticks >= CALM_HI) && ($urandom_range(99) < 21);
                if (tick_backlog.size() != 0 && !drain_hold && !gap)
                begin
                    nxt = tick_backlog.pop_front();
                    tick_ch.valid <= 1'b1;
                    tick_ch.reset_edge <= nxt.rst_e;
                    tick_ch.mute_edge <= nxt.mute_e;
                    tick_ch.start_edge <= nxt.start_e;
                    tick_ch.clock_edge <= nxt.clk_e;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // Beat monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : beat_monitor
        beat_t want;
        if (!rst_n)
            beat_ch.ready <= 1'b0;
        else
        begin
            if (beat_ch.valid && beat_ch.ready)
            begin
                n_beats++;
                if (due_beats.size() == 0)
                begin
                    $error("beat transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (beat_ch.beat_on !== want.beat_on)
                    begin
                        $error("beat_on: expected %0d, got %0d", want.beat_on, beat_ch.beat_on);
                        errors++;
                    end
                    if (beat_ch.accent_on !== want.accent_on)
                    begin
                        $error("accent_on: expected %0d, got %0d",
                               want.accent_on, beat_ch.accent_on);
                        errors++;
                    end
                    if (beat_ch.cycle_end !== want.cycle_end)
                    begin
                        $error("cycle_end: expected %0d, got %0d",
                               want.cycle_end, beat_ch.cycle_end);
                        errors++;
                    end
                    if (beat_ch.is_running !== want.is_running)
                    begin
                        $error("is_running: expected %0d, got %0d",
                               want.is_running, beat_ch.is_running);
                        errors++;
                    end
                    if (beat_ch.step_now !== want.step_now)
                    begin
                        $error("step_now: expected %0d, got %0d", want.step_now, beat_ch.step_now);
                        errors++;
                    end
                end
                if (n_beats == STALL_AT)
                    stall_left = STALL_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                beat_ch.ready <= 1'b0;
            end
            else if (n_beats >= CALM_LO && n_beats < CALM_HI)
                beat_ch.ready <= 1'b1;
            else
                beat_ch.ready <= ($urandom_range(99) >= 21);
        end
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("euclidean_rhythm_step_sequencer verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        int count;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        reset_track();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every combination of edge flags on the reset pattern
        for (int i = 0; i < 16; i++)
            tick_backlog.push_back(tick_t'(i));
        wait_quiet();

        // leader with start wired: runs to the end of the cycle and stops
        write_reg(REG_STEP_TOTAL, 5'd5);
        write_reg(REG_HIT_TOTAL, 5'd3);
        write_reg(REG_ROTATION, 5'd7);
        write_reg(REG_PAD_STEPS, 5'd1);
        write_reg(REG_ACCENT_TOTAL, 5'd2);
        write_reg(REG_ACCENT_SHIFT, 5'd1);
        write_reg(REG_CHAIN_MODE, CFG_W'(CHAIN_LEADER));
        write_reg(REG_START_WIRED, 5'd1);
        end_writes();
        repeat (4) tick_backlog.push_back(tick_t'(4'b0001));
        wait_quiet();

        // shorter pattern with hit and pad totals above it clamped; mode three acts as leader
        write_reg(REG_STEP_TOTAL, 5'd2);
        write_reg(REG_CHAIN_MODE, CFG_W'(CHAIN_LEADER | CHAIN_FOLLOWER));
        write_reg(REG_HIT_TOTAL, 5'd31);
        write_reg(REG_PAD_STEPS, 5'd31);
        end_writes();
        tick_backlog.push_back(tick_t'(4'b0001));
        tick_backlog.push_back(tick_t'(4'b0001));
        tick_backlog.push_back(tick_t'(4'b0010));
        tick_backlog.push_back(tick_t'(4'b0001));
        wait_quiet();

        // empty pattern wraps on every clock
        write_reg(REG_STEP_TOTAL, 5'd0);
        write_reg(REG_CHAIN_MODE, CFG_W'(CHAIN_FREE));
        end_writes();
        tick_backlog.push_back(tick_t'(4'b0001));
        tick_backlog.push_back(tick_t'(4'b0001));
        wait_quiet();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
            begin
                for (int i = 0; i < 8; i++)
                    write_reg(IDX_W'(i), 5'd31);
            end
            else if (ph == 1)
            begin
                for (int i = 0; i < 8; i++)
                    write_reg(IDX_W'(i), 5'd0);
            end
            else if (ph == 2)
            begin
                // full pattern, all accented, follower waiting for start
                write_reg(REG_STEP_TOTAL, 5'd16);
                write_reg(REG_HIT_TOTAL, 5'd16);
                write_reg(REG_ROTATION, 5'd15);
                write_reg(REG_PAD_STEPS, 5'd0);
                write_reg(REG_ACCENT_TOTAL, 5'd16);
                write_reg(REG_ACCENT_SHIFT, 5'd15);
                write_reg(REG_START_WIRED, 5'd1);
                write_reg(REG_CHAIN_MODE, CFG_W'(CHAIN_FOLLOWER));
            end
            else
            begin
                for (int i = 0; i < 8; i++)
                    if ($urandom_range(1) == 1)
                        write_reg(IDX_W'(i), rand_reg(IDX_W'(i)));
            end
            end_writes();
            count = $urandom_range(40, 75);
            repeat (count) tick_backlog.push_back(rand_tick());
            wait_quiet();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("euclidean_rhythm_step_sequencer verification clean");
        else
            $display("euclidean_rhythm_step_sequencer verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/erss_pkg.sv
rtl/core/erss_if.sv
rtl/core/erss_ctrl.sv
rtl/core/erss_dp.sv
rtl/core/euclidean_rhythm_step_sequencer.sv
tb/tb.sv
